// ----- sv/mtcf_pkg.sv -----
// Shared types and constants of the Modbus TCP client framer.
// No dependencies; used by every module of the framer.
package mtcf_pkg;

  // Input item opcodes.
  localparam logic [1:0] OPC_COMMAND  = 2'd0;
  localparam logic [1:0] OPC_PAYLOAD  = 2'd1;
  localparam logic [1:0] OPC_RESPONSE = 2'd2;

  // Command operations.
  localparam logic [2:0] OP_RD_COILS    = 3'd0;
  localparam logic [2:0] OP_RD_DISCRETE = 3'd1;
  localparam logic [2:0] OP_RD_HOLDING  = 3'd2;
  localparam logic [2:0] OP_RD_INPUT    = 3'd3;
  localparam logic [2:0] OP_WR_COIL     = 3'd4;
  localparam logic [2:0] OP_WR_REG      = 3'd5;
  localparam logic [2:0] OP_WR_COILS    = 3'd6;
  localparam logic [2:0] OP_WR_REGS     = 3'd7;

  // Result kinds.
  localparam logic [1:0] KIND_TX_BYTE = 2'd0;
  localparam logic [1:0] KIND_BIT     = 2'd1;
  localparam logic [1:0] KIND_WORD    = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  // Final status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXCEPTION = 2'd1;
  localparam logic [1:0] STATUS_INVALID   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MAX_WRITE_COILS     = 1'b0;
  localparam logic CFG_MAX_WRITE_REGISTERS = 1'b1;

  // Protocol limits.
  localparam logic [10:0] MAX_READ_BITS   = 11'd2000;
  localparam logic [10:0] MAX_READ_WORDS  = 11'd125;
  localparam logic [10:0] MAX_WRITE_COILS = 11'd1968;
  localparam logic [6:0]  MAX_WRITE_REGS  = 7'd123;
  localparam logic [7:0]  EXCEPTION_BIT   = 8'h80;
  localparam logic [7:0]  UNIT_ID         = 8'h01;
  localparam logic [7:0]  SINGLE_LENGTH   = 8'h06;
  localparam logic [15:0] COIL_ON         = 16'hFF00;

  // Kind of work the back end expands into result items.
  typedef enum logic [2:0] {
    JOB_HEADER,
    JOB_BYTES,
    JOB_BITS,
    JOB_WORD,
    JOB_STATUS
  } job_mode_t;

  // One queued job. Fields are reused depending on the mode:
  // header: tid, w0 address, w1 value or quantity, b0 function, b1 byte count.
  // bytes: b0 and b1 in order, cnt of them. bits: b0 data, w0 base index.
  // word: w1 value, w0 index.
  typedef struct packed {
    job_mode_t   mode;
    logic [15:0] tid;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  len;
    logic        ext;
    logic [3:0]  cnt;
    logic        st_en;
    logic [1:0]  st;
    logic [7:0]  ec;
  } job_t;

  // Function code of an operation.
  function automatic logic [7:0] func_code(input logic [2:0] op);
    logic [7:0] f;
    case (op)
      OP_RD_COILS:    f = 8'd1;
      OP_RD_DISCRETE: f = 8'd2;
      OP_RD_HOLDING:  f = 8'd3;
      OP_RD_INPUT:    f = 8'd4;
      OP_WR_COIL:     f = 8'd5;
      OP_WR_REG:      f = 8'd6;
      OP_WR_COILS:    f = 8'd15;
      default:        f = 8'd16;
    endcase
    return f;
  endfunction

endpackage

// ----- sv/mtcf_front.sv -----
// Front end of the framer: takes input items, keeps transaction state and
// turns each item into at most one job. Depends on mtcf_pkg.
module mtcf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       opcode,
  input  logic [2:0]       operation,
  input  logic [15:0]      start_address,
  input  logic [10:0]      quantity,
  input  logic [15:0]      value,
  input  logic [7:0]       response_byte,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [10:0]      cfg_data,
  output logic             job_push,
  output mtcf_pkg::job_t   job
);

  typedef enum logic [1:0] {PH_IDLE, PH_PAYLOAD, PH_AWAIT} phase_t;

  phase_t      phase;
  logic [10:0] max_write_coils;
  logic [6:0]  max_write_registers;
  logic [15:0] transaction_id;
  logic [15:0] hdr_addr;
  logic [15:0] hdr_value;
  logic [2:0]  pending_operation;
  logic [10:0] pending_quantity;
  logic [8:0]  expected_length;
  logic [8:0]  response_count;
  logic [7:0]  coil_pack_byte;
  logic [10:0] element_count;
  logic [7:0]  high_byte_hold;
  logic        exc_flag;
  logic        inv_flag;
  logic [7:0]  exc_code;

  // Command decode.
  logic [10:0] cap;
  logic        single_wr;
  logic        cmd_ok;
  logic [15:0] tid_inc;
  logic [15:0] wr_value;
  logic [11:0] q_plus7;
  logic [7:0]  byte_count;
  logic [8:0]  cmd_exp_len;

  // Payload decode.
  logic [10:0] elem_next;
  logic        pay_done;
  logic [7:0]  pack_next;

  // Response decode.
  logic [8:0]  rc_next;
  logic        rsp_done;
  logic        is_read;
  logic [8:0]  k;
  logic [10:0] bit_base;
  logic [10:0] bit_remain;
  logic [3:0]  bit_count;
  logic        exc_next;
  logic        inv_next;
  logic [7:0]  code_next;
  logic [7:0]  echo_byte;
  logic        echo_check;
  logic        data_ok;
  logic [1:0]  final_status;

  // Command: quantity check, header fields and expected response length.
  always_comb begin
    case (operation)
      mtcf_pkg::OP_RD_COILS, mtcf_pkg::OP_RD_DISCRETE: cap = mtcf_pkg::MAX_READ_BITS;
      mtcf_pkg::OP_RD_HOLDING, mtcf_pkg::OP_RD_INPUT:  cap = mtcf_pkg::MAX_READ_WORDS;
      mtcf_pkg::OP_WR_COILS:
        cap = (max_write_coils < mtcf_pkg::MAX_WRITE_COILS) ? max_write_coils
                                                             : mtcf_pkg::MAX_WRITE_COILS;
      mtcf_pkg::OP_WR_REGS:
        cap = {4'd0, (max_write_registers < mtcf_pkg::MAX_WRITE_REGS) ?
                     max_write_registers : mtcf_pkg::MAX_WRITE_REGS};
      default: cap = 11'd0;
    endcase
    single_wr = (operation == mtcf_pkg::OP_WR_COIL) || (operation == mtcf_pkg::OP_WR_REG);
    cmd_ok    = single_wr || (quantity != 11'd0 && quantity <= cap);
    tid_inc   = transaction_id + 16'd1;
    if (operation == mtcf_pkg::OP_WR_COIL) begin
      wr_value = (value != 16'd0) ? mtcf_pkg::COIL_ON : 16'd0;
    end else if (single_wr) begin
      wr_value = value;
    end else begin
      wr_value = {5'd0, quantity};
    end
    q_plus7 = {1'b0, quantity} + 12'd7;
    case (operation)
      mtcf_pkg::OP_WR_COILS: byte_count = q_plus7[10:3];
      mtcf_pkg::OP_WR_REGS:  byte_count = {quantity[6:0], 1'b0};
      default:               byte_count = 8'd0;
    endcase
    if (operation <= mtcf_pkg::OP_RD_DISCRETE) begin
      cmd_exp_len = 9'd9 + {1'b0, q_plus7[10:3]};
    end else if (operation <= mtcf_pkg::OP_RD_INPUT) begin
      cmd_exp_len = 9'd9 + {quantity[7:0], 1'b0};
    end else begin
      cmd_exp_len = 9'd12;
    end
  end

  // Payload: element count and coil packing.
  always_comb begin
    elem_next = element_count + 11'd1;
    pay_done  = elem_next >= pending_quantity;
    pack_next = coil_pack_byte;
    if (value != 16'd0) begin
      pack_next[element_count[2:0]] = 1'b1;
    end
  end

  // Response: header checks, data unpacking and final status.
  always_comb begin
    rc_next    = response_count + 9'd1;
    rsp_done   = rc_next >= expected_length;
    is_read    = pending_operation <= mtcf_pkg::OP_RD_INPUT;
    k          = response_count - 9'd9;
    bit_base   = {k[7:0], 3'b000};
    bit_remain = pending_quantity - bit_base;
    bit_count  = (bit_remain >= 11'd8) ? 4'd8 : bit_remain[3:0];
    case (response_count)
      9'd0:    echo_byte = transaction_id[15:8];
      9'd1:    echo_byte = transaction_id[7:0];
      9'd5:    echo_byte = mtcf_pkg::SINGLE_LENGTH;
      9'd6:    echo_byte = mtcf_pkg::UNIT_ID;
      9'd7:    echo_byte = mtcf_pkg::func_code(pending_operation);
      9'd8:    echo_byte = hdr_addr[15:8];
      9'd9:    echo_byte = hdr_addr[7:0];
      9'd10:   echo_byte = hdr_value[15:8];
      9'd11:   echo_byte = hdr_value[7:0];
      default: echo_byte = 8'd0;
    endcase
    if (pending_operation <= mtcf_pkg::OP_WR_REG) begin
      echo_check = response_count < 9'd12;
    end else begin
      echo_check = (response_count < 9'd10) && (response_count != 9'd5);
    end
    exc_next  = exc_flag;
    inv_next  = inv_flag;
    code_next = exc_code;
    data_ok   = 1'b0;
    if (is_read) begin
      if (response_count == 9'd7) begin
        if ((response_byte & mtcf_pkg::EXCEPTION_BIT) != 8'd0) begin
          exc_next = 1'b1;
        end else if (response_byte != mtcf_pkg::func_code(pending_operation)) begin
          inv_next = 1'b1;
        end
      end else if (response_count == 9'd8) begin
        if (exc_flag) begin
          code_next = response_byte;
        end
      end else if (response_count >= 9'd9) begin
        data_ok = !exc_flag && !inv_flag;
      end
    end else if (echo_check && response_byte != echo_byte) begin
      inv_next = 1'b1;
    end
    if (exc_next) begin
      final_status = mtcf_pkg::STATUS_EXCEPTION;
    end else if (inv_next) begin
      final_status = mtcf_pkg::STATUS_INVALID;
    end else begin
      final_status = mtcf_pkg::STATUS_OK;
    end
  end

  // Job built from the current item.
  always_comb begin
    job       = '0;
    job.mode  = mtcf_pkg::JOB_STATUS;
    job_push  = 1'b0;
    if (in_valid) begin
      case (opcode)
        mtcf_pkg::OPC_COMMAND: begin
          job_push = 1'b1;
          if (!cmd_ok) begin
            job.st = mtcf_pkg::STATUS_INVALID;
          end else begin
            job.mode = mtcf_pkg::JOB_HEADER;
            job.tid  = tid_inc;
            job.w0   = start_address;
            job.w1   = wr_value;
            job.b0   = mtcf_pkg::func_code(operation);
            job.b1   = byte_count;
            job.ext  = operation >= mtcf_pkg::OP_WR_COILS;
            job.len  = job.ext ? 8'd7 + byte_count : mtcf_pkg::SINGLE_LENGTH;
          end
        end
        mtcf_pkg::OPC_PAYLOAD: begin
          if (phase == PH_PAYLOAD) begin
            job.mode = mtcf_pkg::JOB_BYTES;
            if (pending_operation == mtcf_pkg::OP_WR_COILS) begin
              job.cnt  = 4'd1;
              job.b0   = pack_next;
              job_push = (element_count[2:0] == 3'd7) || pay_done;
            end else begin
              job.cnt  = 4'd2;
              job.b0   = value[15:8];
              job.b1   = value[7:0];
              job_push = 1'b1;
            end
          end
        end
        mtcf_pkg::OPC_RESPONSE: begin
          if (phase == PH_AWAIT) begin
            job.st_en = rsp_done;
            job.st    = final_status;
            job.ec    = (final_status == mtcf_pkg::STATUS_EXCEPTION) ? code_next : 8'd0;
            job_push  = rsp_done;
            if (data_ok && pending_operation <= mtcf_pkg::OP_RD_DISCRETE) begin
              job.mode = mtcf_pkg::JOB_BITS;
              job.b0   = response_byte;
              job.w0   = {5'd0, bit_base};
              job.cnt  = bit_count;
              job_push = 1'b1;
            end else if (data_ok && k[0]) begin
              job.mode = mtcf_pkg::JOB_WORD;
              job.w1   = {high_byte_hold, response_byte};
              job.w0   = {8'd0, k[8:1]};
              job_push = 1'b1;
            end
          end
        end
        default: begin
          job_push = 1'b0;
        end
      endcase
    end
  end

  // Transaction state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      max_write_coils     <= mtcf_pkg::MAX_WRITE_COILS;
      max_write_registers <= mtcf_pkg::MAX_WRITE_REGS;
      transaction_id      <= 16'd1;
      pending_operation   <= mtcf_pkg::OP_RD_COILS;
      pending_quantity    <= 11'd0;
      expected_length     <= 9'd9;
      response_count      <= 9'd0;
      coil_pack_byte      <= 8'd0;
      element_count       <= 11'd0;
      high_byte_hold      <= 8'd0;
      exc_flag            <= 1'b0;
      inv_flag            <= 1'b0;
      exc_code            <= 8'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mtcf_pkg::CFG_MAX_WRITE_COILS:     max_write_coils     <= cfg_data;
          mtcf_pkg::CFG_MAX_WRITE_REGISTERS: max_write_registers <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid) begin
        case (opcode)
          mtcf_pkg::OPC_COMMAND: begin
            if (cmd_ok) begin
              transaction_id    <= tid_inc;
              hdr_addr          <= start_address;
              hdr_value         <= wr_value;
              pending_operation <= operation;
              pending_quantity  <= single_wr ? 11'd0 : quantity;
              expected_length   <= cmd_exp_len;
              response_count    <= 9'd0;
              coil_pack_byte    <= 8'd0;
              element_count     <= 11'd0;
              high_byte_hold    <= 8'd0;
              exc_flag          <= 1'b0;
              inv_flag          <= 1'b0;
              exc_code          <= 8'd0;
              phase             <= (operation >= mtcf_pkg::OP_WR_COILS) ? PH_PAYLOAD
                                                                       : PH_AWAIT;
            end
          end
          mtcf_pkg::OPC_PAYLOAD: begin
            if (phase == PH_PAYLOAD) begin
              element_count <= elem_next;
              if (element_count[2:0] == 3'd7 || pay_done) begin
                coil_pack_byte <= 8'd0;
              end else begin
                coil_pack_byte <= pack_next;
              end
              if (pay_done) begin
                phase <= PH_AWAIT;
              end
            end
          end
          mtcf_pkg::OPC_RESPONSE: begin
            if (phase == PH_AWAIT) begin
              response_count <= rc_next;
              exc_flag       <= exc_next;
              inv_flag       <= inv_next;
              exc_code       <= code_next;
              if (data_ok && !k[0]) begin
                high_byte_hold <= response_byte;
              end
              if (rsp_done) begin
                phase <= PH_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- sv/mtcf_queue.sv -----
// Short job queue between the front and back ends of the framer.
// Depends on mtcf_pkg for the job type.
module mtcf_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mtcf_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output mtcf_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  mtcf_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign valid   = count != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Payload slots need no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/mtcf_back.sv -----
// Back end of the framer: expands queued jobs into result items, one per
// cycle while the output register is free or popped. Depends on mtcf_pkg.
module mtcf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  mtcf_pkg::job_t job,
  output logic           job_pop,
  output logic           empty,
  input  logic           pop,
  output logic [1:0]     kind,
  output logic [7:0]     tx_byte,
  output logic [15:0]    read_value,
  output logic [10:0]    read_index,
  output logic [1:0]     status,
  output logic [7:0]     exception_code,
  output logic           last
);

  logic [3:0]  pos;
  logic [3:0]  item_count;
  logic        take;
  logic        final_item;
  logic        out_valid;
  logic [1:0]  n_kind;
  logic [7:0]  n_tx;
  logic [15:0] n_value;
  logic [10:0] n_index;
  logic [1:0]  n_status;
  logic [7:0]  n_code;

  assign empty      = !out_valid;
  assign take       = job_valid && (!out_valid || pop);
  assign final_item = pos == item_count - 4'd1;
  assign job_pop    = take && final_item;

  // Number of items in the head job.
  always_comb begin
    case (job.mode)
      mtcf_pkg::JOB_HEADER: item_count = job.ext ? 4'd13 : 4'd12;
      mtcf_pkg::JOB_BYTES:  item_count = job.cnt;
      mtcf_pkg::JOB_BITS:   item_count = job.cnt + {3'd0, job.st_en};
      mtcf_pkg::JOB_WORD:   item_count = 4'd1 + {3'd0, job.st_en};
      default:              item_count = 4'd1;
    endcase
  end

  // Item at the current position of the head job.
  always_comb begin
    n_kind   = mtcf_pkg::KIND_STATUS;
    n_tx     = 8'd0;
    n_value  = 16'd0;
    n_index  = 11'd0;
    n_status = job.st;
    n_code   = job.ec;
    case (job.mode)
      mtcf_pkg::JOB_HEADER: begin
        n_kind   = mtcf_pkg::KIND_TX_BYTE;
        n_status = mtcf_pkg::STATUS_OK;
        n_code   = 8'd0;
        case (pos)
          4'd0:    n_tx = job.tid[15:8];
          4'd1:    n_tx = job.tid[7:0];
          4'd5:    n_tx = job.len;
          4'd6:    n_tx = mtcf_pkg::UNIT_ID;
          4'd7:    n_tx = job.b0;
          4'd8:    n_tx = job.w0[15:8];
          4'd9:    n_tx = job.w0[7:0];
          4'd10:   n_tx = job.w1[15:8];
          4'd11:   n_tx = job.w1[7:0];
          4'd12:   n_tx = job.b1;
          default: n_tx = 8'd0;
        endcase
      end
      mtcf_pkg::JOB_BYTES: begin
        n_kind   = mtcf_pkg::KIND_TX_BYTE;
        n_status = mtcf_pkg::STATUS_OK;
        n_code   = 8'd0;
        n_tx     = (pos == 4'd0) ? job.b0 : job.b1;
      end
      mtcf_pkg::JOB_BITS: begin
        if (pos < job.cnt) begin
          n_kind   = mtcf_pkg::KIND_BIT;
          n_status = mtcf_pkg::STATUS_OK;
          n_code   = 8'd0;
          n_value  = {15'd0, job.b0[pos[2:0]]};
          n_index  = job.w0[10:0] + {7'd0, pos};
        end
      end
      mtcf_pkg::JOB_WORD: begin
        if (pos == 4'd0) begin
          n_kind   = mtcf_pkg::KIND_WORD;
          n_status = mtcf_pkg::STATUS_OK;
          n_code   = 8'd0;
          n_value  = job.w1;
          n_index  = job.w0[10:0];
        end
      end
      default: ;
    endcase
  end

  // Position counter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        pos            <= final_item ? 4'd0 : pos + 4'd1;
        out_valid      <= 1'b1;
        kind           <= n_kind;
        tx_byte        <= n_tx;
        read_value     <= n_value;
        read_index     <= n_index;
        status         <= n_status;
        exception_code <= n_code;
        last           <= final_item;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/modbus_tcp_client_framer.sv -----
// Modbus TCP client framer. Every input item is accepted while full is low;
// the front end decodes it at once and queues at most one job, so items
// follow back to back as long as the job queue (QUEUE_DEPTH entries) has
// room. The back end emits one result item per cycle from the queue head
// unless the result port stalls, so the result port sets the sustained
// rate. Depends on mtcf_pkg, mtcf_front, mtcf_queue and mtcf_back.
module modbus_tcp_client_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [2:0]  operation,
  input  logic [15:0] start_address,
  input  logic [10:0] quantity,
  input  logic [15:0] value,
  input  logic        payload_last,
  input  logic [7:0]  response_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic [15:0] read_value,
  output logic [10:0] read_index,
  output logic [1:0]  status,
  output logic [7:0]  exception_code,
  output logic        last,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  logic           in_valid;
  logic           job_push;
  mtcf_pkg::job_t job_in;
  logic           q_valid;
  mtcf_pkg::job_t q_head;
  logic           q_pop;

  // The payload ends on the element count, so the end marker is not needed.
  assign in_valid = push && !full && (payload_last || !payload_last);

  // Front end: decode and transaction state.
  mtcf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .opcode        (opcode),
    .operation     (operation),
    .start_address (start_address),
    .quantity      (quantity),
    .value         (value),
    .response_byte (response_byte),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .job_push      (job_push),
    .job           (job_in)
  );

  // Job queue.
  mtcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job_in),
    .pop      (q_pop),
    .full     (full),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Back end: result expansion.
  mtcf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_valid),
    .job            (q_head),
    .job_pop        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .kind           (kind),
    .tx_byte        (tx_byte),
    .read_value     (read_value),
    .read_index     (read_index),
    .status         (status),
    .exception_code (exception_code),
    .last           (last)
  );

  // A job is only queued for an accepted item.
  assert property (@(posedge clk) disable iff (rst) job_push |-> in_valid)
    else $error("job queued without an accepted item");

  // A final status always closes the run of its item.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == mtcf_pkg::KIND_STATUS) |-> last)
    else $error("status item not marked last");

  // Only status items carry a nonzero status or exception code.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != mtcf_pkg::KIND_STATUS) |->
      (status == mtcf_pkg::STATUS_OK && exception_code == 8'd0))
    else $error("status fields set on a data item");

  // The queue head is only released by the back end while it holds a job.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("job released from an empty queue");

endmodule

// ----- tb/tb_modbus_tcp_client_framer.sv -----
// Self-checking testbench for the Modbus TCP client framer.
// Drives commands, payload elements and server responses, predicts every result item.
// Depends on mtcf_pkg and modbus_tcp_client_framer.
`timescale 1ns / 1ps

module tb_modbus_tcp_client_framer;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int LONG_HOLD      = 400;

  typedef struct {
    logic [1:0]  opc;
    logic [2:0]  op;
    logic [15:0] addr;
    logic [10:0] qty;
    logic [15:0] val;
    logic        plast;
    logic [7:0]  rbyte;
  } cmd_item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [15:0] rval;
    logic [10:0] ridx;
    logic [1:0]  st;
    logic [7:0]  ec;
    logic        last;
  } framer_result_t;

  typedef enum logic [1:0] {PH_IDLE, PH_PAYLOAD, PH_AWAIT} txn_phase_t;

  // Scoreboard: keeps its own copy of the framer state and the expected items.
  class framer_scoreboard;
    logic [10:0] cap_coils = 11'd1968;
    logic [6:0]  cap_regs = 7'd123;
    logic [15:0] tid = 16'd1;
    logic [7:0]  hdr[12];
    logic [2:0]  p_op = 3'd0;
    logic [10:0] p_qty = 11'd0;
    logic [8:0]  rcount = 9'd0;
    logic [7:0]  coil_byte = 8'd0;
    logic [10:0] elem_cnt = 11'd0;
    logic [7:0]  hi_hold = 8'd0;
    logic [9:0]  flags = 10'd0;
    txn_phase_t  phase = PH_IDLE;
    framer_result_t expected_results[$];
    int errors = 0;

    function logic [7:0] fcode(logic [2:0] op);
      case (op)
        mtcf_pkg::OP_RD_COILS:    return 8'd1;
        mtcf_pkg::OP_RD_DISCRETE: return 8'd2;
        mtcf_pkg::OP_RD_HOLDING:  return 8'd3;
        mtcf_pkg::OP_RD_INPUT:    return 8'd4;
        mtcf_pkg::OP_WR_COIL:     return 8'd5;
        mtcf_pkg::OP_WR_REG:      return 8'd6;
        mtcf_pkg::OP_WR_COILS:    return 8'd15;
        default:                  return 8'd16;
      endcase
    endfunction

    function int qty_cap(logic [2:0] op);
      if (op <= mtcf_pkg::OP_RD_DISCRETE) return 2000;
      if (op <= mtcf_pkg::OP_RD_INPUT) return 125;
      if (op == mtcf_pkg::OP_WR_COILS) return (cap_coils < 1968) ? int'(cap_coils) : 1968;
      if (op == mtcf_pkg::OP_WR_REGS) return (cap_regs < 123) ? int'(cap_regs) : 123;
      return 0;
    endfunction

    function int response_len();
      if (p_op <= mtcf_pkg::OP_RD_DISCRETE) return 9 + ((int'(p_qty) + 7) >> 3);
      if (p_op <= mtcf_pkg::OP_RD_INPUT) return 9 + 2 * int'(p_qty);
      return 12;
    endfunction

    function void add(logic [1:0] k, logic [7:0] tx, logic [15:0] rv, logic [10:0] ri,
                      logic [1:0] st, logic [7:0] ec);
      framer_result_t r;
      r = '{k, tx, rv, ri, st, ec, 1'b0};
      expected_results.push_back(r);
    endfunction

    function void write_cfg(logic idx, logic [10:0] data);
      if (idx == mtcf_pkg::CFG_MAX_WRITE_COILS) cap_coils = data;
      else cap_regs = data[6:0];
    endfunction

    function void on_command(cmd_item_t it);
      logic [15:0] v;
      logic [7:0] nbytes;
      int cap;
      v = it.val;
      nbytes = 8'd0;
      cap = qty_cap(it.op);
      if (!(it.op == mtcf_pkg::OP_WR_COIL || it.op == mtcf_pkg::OP_WR_REG) &&
          !(it.qty >= 1 && int'(it.qty) <= cap)) begin
        add(mtcf_pkg::KIND_STATUS, '0, '0, '0, mtcf_pkg::STATUS_INVALID, '0);
        return;
      end
      tid = tid + 16'd1;
      if (it.op == mtcf_pkg::OP_WR_COIL) v = (v != 0) ? mtcf_pkg::COIL_ON : 16'h0000;
      if (it.op == mtcf_pkg::OP_WR_COILS) nbytes = 8'((int'(it.qty) + 7) >> 3);
      if (it.op == mtcf_pkg::OP_WR_REGS) nbytes = 8'(2 * int'(it.qty));
      hdr[0] = tid[15:8];
      hdr[1] = tid[7:0];
      hdr[2] = 8'd0;
      hdr[3] = 8'd0;
      hdr[4] = 8'd0;
      hdr[5] = (it.op >= mtcf_pkg::OP_WR_COILS) ? 8'd7 + nbytes : mtcf_pkg::SINGLE_LENGTH;
      hdr[6] = mtcf_pkg::UNIT_ID;
      hdr[7] = fcode(it.op);
      hdr[8] = it.addr[15:8];
      hdr[9] = it.addr[7:0];
      if (it.op == mtcf_pkg::OP_WR_COIL || it.op == mtcf_pkg::OP_WR_REG) begin
        hdr[10] = v[15:8];
        hdr[11] = v[7:0];
        p_qty = 11'd0;
      end else begin
        hdr[10] = {5'd0, it.qty[10:8]};
        hdr[11] = it.qty[7:0];
        p_qty = it.qty;
      end
      for (int i = 0; i < 12; i++) add(mtcf_pkg::KIND_TX_BYTE, hdr[i], '0, '0, '0, '0);
      if (it.op >= mtcf_pkg::OP_WR_COILS) add(mtcf_pkg::KIND_TX_BYTE, nbytes, '0, '0, '0, '0);
      p_op = it.op;
      rcount = 9'd0;
      coil_byte = 8'd0;
      elem_cnt = 11'd0;
      hi_hold = 8'd0;
      flags = 10'd0;
      phase = (it.op >= mtcf_pkg::OP_WR_COILS) ? PH_PAYLOAD : PH_AWAIT;
    endfunction

    function void on_payload(cmd_item_t it);
      logic [10:0] idx;
      logic done;
      if (phase != PH_PAYLOAD) return;
      idx = elem_cnt;
      elem_cnt = elem_cnt + 11'd1;
      done = (elem_cnt >= p_qty);
      if (p_op == mtcf_pkg::OP_WR_COILS) begin
        if (it.val != 0) coil_byte[idx[2:0]] = 1'b1;
        if (idx[2:0] == 3'd7 || done) begin
          add(mtcf_pkg::KIND_TX_BYTE, coil_byte, '0, '0, '0, '0);
          coil_byte = 8'd0;
        end
      end else begin
        add(mtcf_pkg::KIND_TX_BYTE, it.val[15:8], '0, '0, '0, '0);
        add(mtcf_pkg::KIND_TX_BYTE, it.val[7:0], '0, '0, '0, '0);
      end
      if (done) phase = PH_AWAIT;
    endfunction

    function void on_response(cmd_item_t it);
      logic [7:0] b;
      int i;
      int k;
      logic chk;
      if (phase != PH_AWAIT) return;
      b = it.rbyte;
      i = int'(rcount);
      if (p_op <= mtcf_pkg::OP_RD_INPUT) begin
        if (i == 7) begin
          if ((b & mtcf_pkg::EXCEPTION_BIT) != 0) flags[0] = 1'b1;
          else if (b != fcode(p_op)) flags[1] = 1'b1;
        end else if (i == 8) begin
          if (flags[0]) flags = flags | {b, 2'b00};
        end else if (i >= 9 && flags[1:0] == 2'b00) begin
          k = i - 9;
          if (p_op <= mtcf_pkg::OP_RD_DISCRETE) begin
            for (int j = 0; j < 8 && k * 8 + j < int'(p_qty); j++)
              add(mtcf_pkg::KIND_BIT, '0, {15'd0, b[j]}, 11'(k * 8 + j), '0, '0);
          end else if ((k & 1) == 0) begin
            hi_hold = b;
          end else begin
            add(mtcf_pkg::KIND_WORD, '0, {hi_hold, b}, 11'(k >> 1), '0, '0);
          end
        end
      end else begin
        // Write responses echo the request; the length byte of a multiple is not compared.
        chk = (p_op <= mtcf_pkg::OP_WR_REG) ? (i < 12) : (i < 10 && i != 5);
        if (chk && b != hdr[i]) flags[1] = 1'b1;
      end
      rcount = rcount + 9'd1;
      if (int'(rcount) >= response_len()) begin
        if (flags[0])
          add(mtcf_pkg::KIND_STATUS, '0, '0, '0, mtcf_pkg::STATUS_EXCEPTION, flags[9:2]);
        else if (flags[1])
          add(mtcf_pkg::KIND_STATUS, '0, '0, '0, mtcf_pkg::STATUS_INVALID, '0);
        else
          add(mtcf_pkg::KIND_STATUS, '0, '0, '0, mtcf_pkg::STATUS_OK, '0);
        phase = PH_IDLE;
      end
    endfunction

    // Note an accepted input item and queue the result items it causes.
    function void note_item(cmd_item_t it);
      int n0;
      n0 = expected_results.size();
      case (it.opc)
        mtcf_pkg::OPC_COMMAND:  on_command(it);
        mtcf_pkg::OPC_PAYLOAD:  on_payload(it);
        mtcf_pkg::OPC_RESPONSE: on_response(it);
        default: ;
      endcase
      if (expected_results.size() > n0) expected_results[$].last = 1'b1;
    endfunction

    // Compare an accepted result item against the oldest expectation.
    function void check_result(framer_result_t act);
      framer_result_t e;
      if (expected_results.size() == 0) begin
        $error("unexpected result item: kind %0d tx %0h", act.kind, act.tx);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (act.kind !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, act.kind); errors++;
      end
      if (act.tx !== e.tx) begin
        $error("tx_byte: expected %0h, actual %0h", e.tx, act.tx); errors++;
      end
      if (act.rval !== e.rval) begin
        $error("read_value: expected %0h, actual %0h", e.rval, act.rval); errors++;
      end
      if (act.ridx !== e.ridx) begin
        $error("read_index: expected %0d, actual %0d", e.ridx, act.ridx); errors++;
      end
      if (act.st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, act.st); errors++;
      end
      if (act.ec !== e.ec) begin
        $error("exception_code: expected %0h, actual %0h", e.ec, act.ec); errors++;
      end
      if (act.last !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, act.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode = '0;
  logic [2:0]  operation = '0;
  logic [15:0] start_address = '0;
  logic [10:0] quantity = '0;
  logic [15:0] value = '0;
  logic        payload_last = 1'b0;
  logic [7:0]  response_byte = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [15:0] read_value;
  logic [10:0] read_index;
  logic [1:0]  status;
  logic [7:0]  exception_code;
  logic        last;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;

  framer_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  int stall_wd = 0;
  int items_sent = 0;

  modbus_tcp_client_framer dut (.*);

  always #6 clk = ~clk;

  // Result side: check accepted items, stall at random or for a long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty)
        sb.check_result('{kind, tx_byte, read_value, read_index, status, exception_code, last});
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog on cycles where neither side moves an item.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stall_wd <= 0;
      else stall_wd <= stall_wd + 1;
      if (stall_wd >= WATCHDOG_LIMIT) begin
        $display("[modbus_tcp_client_framer] ERROR");
        $finish;
      end
    end
  end

  function automatic cmd_item_t rand_item(logic [1:0] opc);
    cmd_item_t it;
    it.opc = opc;
    it.op = 3'($urandom);
    it.addr = 16'($urandom);
    it.qty = 11'($urandom);
    it.val = 16'($urandom);
    it.plast = 1'($urandom);
    it.rbyte = 8'($urandom);
    return it;
  endfunction

  // Offer one item and wait until the framer takes it.
  task automatic send(cmd_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    opcode <= it.opc;
    operation <= it.op;
    start_address <= it.addr;
    quantity <= it.qty;
    value <= it.val;
    payload_last <= it.plast;
    response_byte <= it.rbyte;
    do @(posedge clk); while (full);
    sb.note_item(it);
    items_sent++;
  endtask

  // Stop offering and wait until every expected item has come out.
  task automatic drain();
    push <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [10:0] data);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_cfg(idx, data);
  endtask

  // One transaction: command, payload if needed, then a server response.
  // resp_mode: 0 clean, 1 exception, 2 function or echo mismatch.
  // cut > 0 stops the payload or response early so the next command abandons it.
  task automatic transaction(logic [2:0] op, logic [10:0] qty, logic [15:0] val,
                             int resp_mode, int cut);
    cmd_item_t it;
    int n;
    int bad;
    it = rand_item(mtcf_pkg::OPC_COMMAND);
    it.op = op;
    it.qty = qty;
    it.val = val;
    send(it);
    n = 0;
    while (sb.phase == PH_PAYLOAD) begin
      if (cut > 0 && n == cut) return;
      it = rand_item(mtcf_pkg::OPC_PAYLOAD);
      if (op == mtcf_pkg::OP_WR_COILS && $urandom_range(1)) it.val = 16'd0;
      it.plast = (sb.elem_cnt + 1 == sb.p_qty);
      send(it);
      n++;
    end
    if (sb.phase != PH_AWAIT) return;
    n = sb.response_len();
    bad = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      if (cut > 0 && i == cut) return;
      it = rand_item(mtcf_pkg::OPC_RESPONSE);
      if (op <= mtcf_pkg::OP_RD_INPUT) begin
        if (i == 7) begin
          if (resp_mode == 1) it.rbyte = sb.fcode(op) | mtcf_pkg::EXCEPTION_BIT;
          else if (resp_mode == 2) it.rbyte = sb.fcode(3'(op + 1 + $urandom_range(6)));
          else it.rbyte = sb.fcode(op);
        end else if (i == 8 && resp_mode != 1) begin
          it.rbyte = 8'(n - 9);
        end
      end else if (i < 12 && !(op >= mtcf_pkg::OP_WR_COILS && (i == 5 || i >= 10))) begin
        it.rbyte = sb.hdr[i];
        if (resp_mode == 2 && i == (bad % 10) && i != 5) it.rbyte = ~sb.hdr[i];
      end
      send(it);
    end
  endtask

  task automatic random_phase(int n_items);
    int stop_at;
    int r;
    int cap;
    logic [2:0] op;
    logic [10:0] q;
    cmd_item_t it;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 6) begin
        // Noise: stray payload, stray response byte, or an unused opcode.
        it = rand_item(2'($urandom_range(3)));
        if (it.opc == mtcf_pkg::OPC_COMMAND) it.opc = 2'd3;
        send(it);
      end else begin
        op = 3'($urandom);
        cap = sb.qty_cap(op);
        r = $urandom_range(99);
        if (r < 60) q = 11'($urandom_range(1, 12));
        else if (r < 75) q = (cap > 0 && cap <= 40) ? 11'(cap) : 11'($urandom_range(1, 40));
        else if (r < 85) q = 11'(cap + 1);
        else if (r < 95) q = 11'd0;
        else q = 11'($urandom_range(cap + 1, 2047));
        r = $urandom_range(99);
        transaction(op, q, 16'($urandom), (r < 70) ? 0 : (r < 85) ? 1 : 2,
                    ($urandom_range(19) == 0) ? $urandom_range(1, 6) : 0);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: limits, every operation, exceptions, mismatches, abandon and noise.
    // The largest accepted counts are cut short and abandoned by the next command.
    tx_idle_pct = 20;
    rx_idle_pct = 60;
    send(rand_item(2'd3));
    send(rand_item(mtcf_pkg::OPC_PAYLOAD));
    send(rand_item(mtcf_pkg::OPC_RESPONSE));
    transaction(mtcf_pkg::OP_RD_COILS, 11'd1, 16'd0, 0, 0);
    transaction(mtcf_pkg::OP_RD_COILS, 11'd2001, 16'd0, 0, 0);
    transaction(mtcf_pkg::OP_RD_INPUT, 11'd126, 16'd0, 0, 0);
    transaction(mtcf_pkg::OP_RD_HOLDING, 11'd0, 16'd0, 0, 0);
    transaction(mtcf_pkg::OP_RD_DISCRETE, 11'd2000, 16'd0, 0, 12);
    transaction(mtcf_pkg::OP_RD_HOLDING, 11'd125, 16'd0, 0, 12);
    transaction(mtcf_pkg::OP_RD_INPUT, 11'd3, 16'd0, 1, 0);
    transaction(mtcf_pkg::OP_RD_DISCRETE, 11'd9, 16'd0, 2, 0);
    transaction(mtcf_pkg::OP_WR_COIL, 11'd0, 16'h0001, 0, 0);
    transaction(mtcf_pkg::OP_WR_COIL, 11'd5, 16'h0000, 2, 0);
    transaction(mtcf_pkg::OP_WR_REG, 11'd0, 16'hFFFF, 0, 0);
    transaction(mtcf_pkg::OP_WR_COILS, 11'd17, 16'd0, 0, 0);
    transaction(mtcf_pkg::OP_WR_REGS, 11'd124, 16'd0, 0, 0);
    transaction(mtcf_pkg::OP_WR_REGS, 11'd123, 16'd0, 0, 4);
    transaction(mtcf_pkg::OP_WR_COILS, 11'd10, 16'd0, 2, 0);
    transaction(mtcf_pkg::OP_WR_REGS, 11'd4, 16'd0, 0, 3);
    transaction(mtcf_pkg::OP_RD_HOLDING, 11'd4, 16'd0, 0, 9);
    transaction(mtcf_pkg::OP_RD_COILS, 11'd7, 16'd0, 0, 0);

    // Smallest write caps.
    write_cfg(mtcf_pkg::CFG_MAX_WRITE_COILS, 11'd1);
    write_cfg(mtcf_pkg::CFG_MAX_WRITE_REGISTERS, 11'd1);
    random_phase(30);

    // Caps above the protocol limits; sender often idle, receiver eager.
    tx_idle_pct = 60;
    rx_idle_pct = 20;
    write_cfg(mtcf_pkg::CFG_MAX_WRITE_COILS, 11'd2047);
    write_cfg(mtcf_pkg::CFG_MAX_WRITE_REGISTERS, 11'd127);
    random_phase(30);

    // Mid caps, no idling, with a long receiver hold-off and a full drain.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_cfg(mtcf_pkg::CFG_MAX_WRITE_COILS, 11'($urandom_range(2, 40)));
    write_cfg(mtcf_pkg::CFG_MAX_WRITE_REGISTERS, 11'($urandom_range(2, 60)));
    hold_req = 1'b1;
    random_phase(15);
    drain();
    random_phase(15);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("[modbus_tcp_client_framer] OK");
    end else begin
      $display("[modbus_tcp_client_framer] ERROR");
    end
    $finish;
  end

endmodule
